[rtl/leb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_pkg
// Types and constants shared by the line edit buffer modules.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int unsigned CharW = 7;
  localparam int unsigned KeyW  = 8;
  localparam int unsigned OpW   = 2;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned OutW  = 7;
  localparam int unsigned RdW   = 8;

  typedef enum logic [OpW-1:0] {
    OP_KEY   = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  localparam logic [KeyW-1:0] KEY_FIRST_PRINTABLE = 8'd32;
  localparam logic [KeyW-1:0] KEY_LAST_PRINTABLE  = 8'd126;
  localparam logic [KeyW-1:0] KEY_BACKSPACE       = 8'd8;
  localparam logic [KeyW-1:0] KEY_DELETE          = 8'd127;

  localparam logic [OutW-1:0] MAX_LENGTH_RESET = 7'd64;

  // Broadcast to every cell: open a gap (ins) or close one (rem) at a position
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [CharW-1:0] ch;
  } shift_cmd_t;

endpackage

[rtl/leb_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_cell
// One character slot of the line; takes from a neighbour on insert or delete.
// ----------------------------------------------------------------------------
module leb_cell
  import leb_pkg::*;
#(
  parameter int unsigned Capacity = 64,
  parameter int unsigned Index    = 0,
  localparam int unsigned PosW    = $clog2(Capacity + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  shift_cmd_t       cmd_i,
  input  logic [PosW-1:0]  pos_i,
  input  logic [CharW-1:0] left_i,
  input  logic [CharW-1:0] right_i,
  output logic [CharW-1:0] char_o
);

  localparam logic [PosW-1:0] MyPos = PosW'(Index);

  logic [CharW-1:0] char_d, char_q;

  always_comb begin
    char_d = char_q;
    if (cmd_i.ins) begin
      if (MyPos == pos_i) begin
        char_d = cmd_i.ch;
      end else if (MyPos > pos_i) begin
        char_d = left_i;
      end
    end else if (cmd_i.rem) begin
      // close the gap: everything from the removed slot upward moves down
      if (MyPos >= pos_i) begin
        char_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else begin
      char_q <= char_d;
    end
  end

  assign char_o = char_q;

endmodule

[rtl/leb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_ctrl
// Decodes a transaction, keeps cursor, length and limit, drives the cell row.
// ----------------------------------------------------------------------------
module leb_ctrl
  import leb_pkg::*;
#(
  parameter int unsigned Capacity = 64,
  localparam int unsigned PosW    = $clog2(Capacity + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [OpW-1:0]  op_i,
  input  logic [KeyW-1:0] key_i,
  input  logic            cfg_we_i,
  input  logic [OutW-1:0] cfg_wdata_i,
  output shift_cmd_t      cmd_o,
  output logic [PosW-1:0] pos_o,
  output logic [PosW-1:0] cursor_o,
  output logic [PosW-1:0] length_o,
  output logic            changed_o
);

  localparam int unsigned LimW = (PosW > OutW) ? PosW : OutW;

  logic [PosW-1:0] cursor_d, cursor_q;
  logic [PosW-1:0] length_d, length_q;
  logic [OutW-1:0] max_length_q;
  logic            full;
  logic            is_print;
  op_e             op;

  assign op = op_e'(op_i);

  // limit saturates at the capacity of the row
  assign full = (length_q >= PosW'(Capacity)) ||
                (LimW'(length_q) >= LimW'(max_length_q));

  always_comb begin
    is_print = key_i inside {[KEY_FIRST_PRINTABLE:KEY_LAST_PRINTABLE]};
  end

  always_comb begin
    cmd_o.ins = 1'b0;
    cmd_o.rem = 1'b0;
    cmd_o.ch  = key_i[CharW-1:0];
    pos_o     = cursor_q;
    cursor_d  = cursor_q;
    length_d  = length_q;
    changed_o = 1'b0;
    if (start_i) begin
      case (op)
        OP_KEY: begin
          if (is_print) begin
            if (!full) begin
              cmd_o.ins = 1'b1;
              cursor_d  = cursor_q + 1'b1;
              length_d  = length_q + 1'b1;
              changed_o = 1'b1;
            end
          end else if (key_i == KEY_BACKSPACE) begin
            if (cursor_q != '0) begin
              cmd_o.rem = 1'b1;
              pos_o     = cursor_q - 1'b1;
              cursor_d  = cursor_q - 1'b1;
              length_d  = length_q - 1'b1;
              changed_o = 1'b1;
            end
          end else if (key_i == KEY_DELETE) begin
            if (cursor_q < length_q) begin
              cmd_o.rem = 1'b1;
              length_d  = length_q - 1'b1;
              changed_o = 1'b1;
            end
          end
        end
        OP_LEFT: begin
          if (cursor_q != '0) begin
            cursor_d  = cursor_q - 1'b1;
            changed_o = 1'b1;
          end
        end
        OP_RIGHT: begin
          if (cursor_q < length_q) begin
            cursor_d  = cursor_q + 1'b1;
            changed_o = 1'b1;
          end
        end
        default: begin
          // read: no state change
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q     <= '0;
      length_q     <= '0;
      max_length_q <= MAX_LENGTH_RESET;
    end else begin
      cursor_q <= cursor_d;
      length_q <= length_d;
      if (cfg_we_i) begin
        max_length_q <= cfg_wdata_i;
      end
    end
  end

  assign cursor_o = cursor_q;
  assign length_o = length_q;

  a_cursor_in_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= length_q)
    else $error("cursor beyond end of line");

  a_length_in_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    length_q <= PosW'(Capacity))
    else $error("length beyond capacity");

  a_one_shift : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.ins && cmd_o.rem))
    else $error("insert and remove in one cycle");

  a_ins_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins |=> (length_q == PosW'($past(length_q) + 1'b1)))
    else $error("insert did not grow the line");

  a_rem_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rem |=> (length_q == PosW'($past(length_q) - 1'b1)))
    else $error("remove did not shrink the line");

endmodule

[rtl/line_edit_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_buffer
// One-line text buffer with cursor, held in a row of character cells.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a clock edge with start_i high (busy_o is held
//   low, so one transaction may follow another every cycle). op_i selects a
//   key press (key_i), cursor left, cursor right or a read of read_index_i.
//   In the cycle after acceptance done_o pulses for one cycle with the
//   cursor, length, read character and changed flag after that transaction.
//   Throughput is one transaction per cycle: the whole insert or delete
//   shift happens in the cell row at the accepting edge, each cell taking
//   from its left or right neighbour.
//   The receiver cannot stall; results are presented once and dropped.
//   max_length_i is written with max_length_we_i while no transaction is in
//   flight (user's duty, not enforced); the limit saturates at Capacity.
//   Reset clears every cell, the cursor and the length, and sets the limit
//   to 64; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module line_edit_buffer
  import leb_pkg::*;
#(
  parameter int unsigned Capacity = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [OpW-1:0]  op_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [IdxW-1:0] read_index_i,
  input  logic            max_length_we_i,
  input  logic [OutW-1:0] max_length_i,
  output logic            done_o,
  output logic [OutW-1:0] cursor_o,
  output logic [OutW-1:0] length_o,
  output logic [RdW-1:0]  read_char_o,
  output logic            changed_o
);

  localparam int unsigned PosW   = $clog2(Capacity + 1);
  localparam int unsigned IdxCmW = (PosW > IdxW) ? PosW : IdxW;

  shift_cmd_t       cmd;
  logic [PosW-1:0]  pos;
  logic [PosW-1:0]  cursor;
  logic [PosW-1:0]  length;
  logic             changed;
  logic [CharW-1:0] chars [Capacity];
  logic [CharW-1:0] sel_char;
  logic [IdxCmW-1:0] idx_ext;
  logic             rd_hit;
  logic [RdW-1:0]   read_char_d, read_char_q;
  logic             changed_q, done_q;

  leb_ctrl #(
    .Capacity (Capacity)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .op_i        (op_i),
    .key_i       (key_i),
    .cfg_we_i    (max_length_we_i),
    .cfg_wdata_i (max_length_i),
    .cmd_o       (cmd),
    .pos_o       (pos),
    .cursor_o    (cursor),
    .length_o    (length),
    .changed_o   (changed)
  );

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [CharW-1:0] left_ch, right_ch;
    if (i == 0) begin : g_first
      assign left_ch = '0;
    end else begin : g_mid_l
      assign left_ch = chars[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right_ch = '0;
    end else begin : g_mid_r
      assign right_ch = chars[i+1];
    end
    leb_cell #(
      .Capacity (Capacity),
      .Index    (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .pos_i   (pos),
      .left_i  (left_ch),
      .right_i (right_ch),
      .char_o  (chars[i])
    );
  end

  assign idx_ext = IdxCmW'(read_index_i);

  always_comb begin
    sel_char = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (idx_ext == IdxCmW'(i)) begin
        sel_char = chars[i];
      end
    end
  end

  // a read past the end of the line returns zero
  assign rd_hit      = start_i && (op_e'(op_i) == OP_READ) && (idx_ext < IdxCmW'(length));
  assign read_char_d = rd_hit ? {1'b0, sel_char} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      read_char_q <= '0;
      changed_q   <= 1'b0;
    end else begin
      done_q      <= start_i;
      read_char_q <= read_char_d;
      changed_q   <= changed;
    end
  end

  assign busy_o      = 1'b0;
  assign done_o      = done_q;
  assign cursor_o    = OutW'(cursor);
  assign length_o    = OutW'(length);
  assign read_char_o = read_char_q;
  assign changed_o   = changed_q;

endmodule
